// File: rtl/tbgd_pkg.sv
// shared constants and types for the two-button gesture detector
package tbgd_pkg;

  localparam int unsigned Buttons  = 2;
  localparam int unsigned CntW     = 8;
  localparam int unsigned CmdW     = 4;
  localparam int unsigned CmdCntW  = 5;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  // register indexes, at byte address 4 * index
  localparam logic [2:0] RegTapMin    = 3'd0;
  localparam logic [2:0] RegHoldCount = 3'd1;
  localparam logic [2:0] RegDblWindow = 3'd2;
  localparam logic [2:0] RegComboHold = 3'd3;
  localparam logic [2:0] RegCmdCount  = 3'd4;

  localparam logic [CntW-1:0]    TapMinRst    = 8'd5;
  localparam logic [CntW-1:0]    HoldCountRst = 8'd80;
  localparam logic [CntW-1:0]    DblWindowRst = 8'd20;
  localparam logic [CntW-1:0]    ComboHoldRst = 8'd65;
  localparam logic [CmdCntW-1:0] CmdCountRst  = 5'd9;

  // result beat, packed from the msb down to b0_tap in bit 0
  typedef struct packed {
    logic            pad;
    logic            send_request;
    logic [CmdW-1:0] command_pick;
    logic            setup_now;
    logic            setup_toggled;
    logic            b1_release;
    logic            b1_hold;
    logic            b1_double;
    logic            b1_tap;
    logic            b0_release;
    logic            b0_hold;
    logic            b0_double;
    logic            b0_tap;
  } result_t;

endpackage

// File: rtl/two_button_gesture_detector_unit.sv
// two-button tap, double tap, hold and release detector with setup mode and command index
// the result beat of an accepted input beat is registered and shown on the master side in the next cycle
// throughput: one beat per cycle while the master side takes results; the button update is a single combinational pass
//   from the state registers into the state and result registers
// a held result beat does not stall input while the result register can be emptied
// reset: asynchronous, active low; state cleared, registers back to their defaults
module two_button_gesture_detector_unit
  import tbgd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  // input ticks
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // btn0 level, btn1 level, link busy, zero
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // b0_tap, b0_double, b0_hold, b0_release,
                                              // b1_tap, b1_double, b1_hold, b1_release,
                                              // setup_toggled, setup_now, command_pick[3:0],
                                              // send_request, zero
);

  // configuration registers
  logic [CntW-1:0]    tap_min_q, hold_count_q, dbl_window_q, combo_hold_q;
  logic [CmdCntW-1:0] cmd_count_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_min_q    <= TapMinRst;
      hold_count_q <= HoldCountRst;
      dbl_window_q <= DblWindowRst;
      combo_hold_q <= ComboHoldRst;
      cmd_count_q  <= CmdCountRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegTapMin:    tap_min_q    <= pwdata[CntW-1:0];
        RegHoldCount: hold_count_q <= pwdata[CntW-1:0];
        RegDblWindow: dbl_window_q <= pwdata[CntW-1:0];
        RegComboHold: combo_hold_q <= pwdata[CntW-1:0];
        RegCmdCount:  cmd_count_q  <= pwdata[CmdCntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegTapMin:    prdata = {{(DataW-CntW){1'b0}}, tap_min_q};
      RegHoldCount: prdata = {{(DataW-CntW){1'b0}}, hold_count_q};
      RegDblWindow: prdata = {{(DataW-CntW){1'b0}}, dbl_window_q};
      RegComboHold: prdata = {{(DataW-CntW){1'b0}}, combo_hold_q};
      RegCmdCount:  prdata = {{(DataW-CmdCntW){1'b0}}, cmd_count_q};
      default:      prdata = '0;
    endcase
  end

  // gesture state
  logic [CntW-1:0] press_q   [Buttons];
  logic [CntW-1:0] press_d   [Buttons];
  logic [CntW-1:0] release_q [Buttons];
  logic [CntW-1:0] release_d [Buttons];
  logic [Buttons-1:0] tap_armed_q, tap_armed_d;
  logic [Buttons-1:0] dbl_armed_q, dbl_armed_d;
  logic [Buttons-1:0] hold_on_q, hold_on_d;
  logic               lock_q, lock_d;
  logic               setup_q, setup_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;

  logic [Buttons-1:0] ev_tap, ev_dbl, ev_hold, ev_rel;
  logic               ev_toggle, ev_send;

  logic    in_fire, out_fire;
  logic    out_valid_q;
  result_t res_q, res_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // button 0 then button 1, button 1 seeing what button 0 left
  always_comb begin
    logic idx;
    logic pressed;
    logic busy;
    press_d     = press_q;
    release_d   = release_q;
    tap_armed_d = tap_armed_q;
    dbl_armed_d = dbl_armed_q;
    hold_on_d   = hold_on_q;
    lock_d      = lock_q;
    setup_d     = setup_q;
    cmd_d       = cmd_q;
    ev_tap      = '0;
    ev_dbl      = '0;
    ev_hold     = '0;
    ev_rel      = '0;
    ev_toggle   = 1'b0;
    ev_send     = 1'b0;
    busy        = s_axis_tdata[2];
    for (int b = 0; b < Buttons; b++) begin
      idx     = 1'(b);
      pressed = s_axis_tdata[idx];
      if (!busy) begin
        if (pressed) begin
          if (press_d[idx] != CntMax && !lock_d) press_d[idx] = press_d[idx] + 8'd1;
          if (press_d[0] >= combo_hold_q && press_d[1] >= combo_hold_q) begin
            press_d[0] = '0;
            press_d[1] = '0;
            lock_d     = 1'b1;
            setup_d    = !setup_d;
            ev_toggle  = 1'b1;
          end
          if (tap_armed_d[idx] && release_d[idx] <= dbl_window_q) dbl_armed_d[idx] = 1'b1;
          if (press_d[idx] == hold_count_q) begin
            hold_on_d[idx] = 1'b1;
            ev_hold[idx]   = 1'b1;
          end
        end else begin
          if (tap_armed_d[idx] && release_d[idx] != CntMax)
            release_d[idx] = release_d[idx] + 8'd1;
          if (press_d[idx] > tap_min_q && press_d[idx] < hold_count_q) begin
            if (dbl_armed_d[idx]) begin
              release_d[idx]   = '0;
              tap_armed_d[idx] = 1'b0;
              dbl_armed_d[idx] = 1'b0;
              ev_dbl[idx]      = 1'b1;
            end else begin
              tap_armed_d[idx] = 1'b1;
            end
          end
          if (tap_armed_d[idx] && release_d[idx] > dbl_window_q) begin
            tap_armed_d[idx] = 1'b0;
            release_d[idx]   = '0;
            ev_tap[idx]      = 1'b1;
            if (idx == 1'b0) begin
              // step down, wrapping to the top command
              if (cmd_d == '0) cmd_d = CmdW'(cmd_count_q - 5'd1);
              else             cmd_d = cmd_d - 4'd1;
            end else begin
              ev_send = 1'b1;
            end
          end
          press_d[idx] = '0;
          lock_d       = 1'b0;
          if (hold_on_d[idx]) ev_rel[idx] = 1'b1;
          hold_on_d[idx] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_d               = '0;
    res_d.b0_tap        = ev_tap[0];
    res_d.b0_double     = ev_dbl[0];
    res_d.b0_hold       = ev_hold[0];
    res_d.b0_release    = ev_rel[0];
    res_d.b1_tap        = ev_tap[1];
    res_d.b1_double     = ev_dbl[1];
    res_d.b1_hold       = ev_hold[1];
    res_d.b1_release    = ev_rel[1];
    res_d.setup_toggled = ev_toggle;
    res_d.setup_now     = setup_d;
    res_d.command_pick  = cmd_d;
    res_d.send_request  = ev_send;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < Buttons; b++) begin
        press_q[b]   <= '0;
        release_q[b] <= '0;
      end
      tap_armed_q <= '0;
      dbl_armed_q <= '0;
      hold_on_q   <= '0;
      lock_q      <= 1'b0;
      setup_q     <= 1'b0;
      cmd_q       <= '0;
    end else if (in_fire) begin
      press_q     <= press_d;
      release_q   <= release_d;
      tap_armed_q <= tap_armed_d;
      dbl_armed_q <= dbl_armed_d;
      hold_on_q   <= hold_on_d;
      lock_q      <= lock_d;
      setup_q     <= setup_d;
      cmd_q       <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;

endmodule
